@@ design/texel_coordinate_wrap_macros.svh @@
// assertion helpers for the texel coordinate wrap block
`ifndef TEXEL_COORDINATE_WRAP_MACROS_SVH
`define TEXEL_COORDINATE_WRAP_MACROS_SVH

`ifndef ASSERT_OFF

// consequent checked in the same cycle
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("texel_coordinate_wrap: check failed");

// consequent checked in the following cycle
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("texel_coordinate_wrap: check failed");

`else

`define TCW_ASSERT_NOW(label, ante, cons)

`define TCW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/tcw_pkg.sv @@
package tcw_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int TEXEL_W     = 12;
    // remainder bits resolved per divider stage
    localparam int BPS         = 4;
    // multiply, round, flip, abs/clamp
    localparam int NPRE        = 4;
    localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

    typedef enum logic [1:0] {
        WRAP_REPEAT  = 2'd0,
        WRAP_MIRROR  = 2'd1,
        WRAP_CLAMP   = 2'd2,
        WRAP_INVALID = 2'd3
    } wrap_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_WRAP_S       = 3'd2,
        CFG_WRAP_T       = 3'd3,
        CFG_ORIGIN       = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        wrap_kind_t mode;
        logic       flip;
    } lane_cfg_t;

    function automatic int size_width(input int max_dim);
        return $clog2(max_dim + 1);
    endfunction

    // width of |v| after rounding and row flip
    function automatic int abs_width(input int sw);
        return sw + COORD_W - FRAC_W + 2;
    endfunction

    function automatic int div_stages(input int aw);
        return (aw + BPS - 1) / BPS;
    endfunction

    function automatic int num_stages(input int max_dim);
        return NPRE + div_stages(abs_width(size_width(max_dim)));
    endfunction

endpackage

@@ design/tcw_rem_step.sv @@
module tcw_rem_step #(
    parameter int SW  = 13,
    parameter int DVW = 32
) (
    input  logic           aclk,
    input  logic           load,
    input  logic [SW-1:0]  size,
    input  logic [SW-1:0]  rem_in,
    input  logic [DVW-1:0] dvd_in,
    output logic [SW-1:0]  rem_out,
    output logic [DVW-1:0] dvd_out
);

    logic [SW-1:0]  rem_reg;
    logic [SW-1:0]  rem_next;
    logic [DVW-1:0] dvd_reg;
    logic [SW:0]    trial;

    // restoring remainder, one dividend bit per step, msb first
    always_comb begin
        rem_next = rem_in;
        trial    = '0;
        for (int i = 0; i < tcw_pkg::BPS; i++) begin
            trial = {rem_next, dvd_in[DVW-1-i]};
            if (trial >= {1'b0, size}) begin
                trial = trial - {1'b0, size};
            end
            rem_next = trial[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_in << tcw_pkg::BPS;
        end
    end

    assign rem_out = rem_reg;
    assign dvd_out = dvd_reg;

endmodule

@@ design/tcw_lane.sv @@
module tcw_lane #(
    parameter int MAX_DIM = tcw_pkg::MAX_DIM_DEF
) (
    input  logic                                      aclk,
    input  logic [tcw_pkg::num_stages(MAX_DIM)-1:0]   load,
    input  logic [tcw_pkg::size_width(MAX_DIM)-1:0]   size,
    input  tcw_pkg::lane_cfg_t                        cfg,
    input  logic signed [tcw_pkg::COORD_W-1:0]        coord,
    output logic [tcw_pkg::TEXEL_W-1:0]               texel
);

    localparam int SW   = tcw_pkg::size_width(MAX_DIM);
    localparam int PW   = tcw_pkg::COORD_W + SW;
    localparam int RW   = PW - tcw_pkg::FRAC_W + 1;
    localparam int VW   = RW + 2;
    localparam int AW   = tcw_pkg::abs_width(SW);
    localparam int NDIV = tcw_pkg::div_stages(AW);
    localparam int DVW  = NDIV * tcw_pkg::BPS;
    localparam int NPRE = tcw_pkg::NPRE;

    logic [SW-1:0] size_m1;

    logic [tcw_pkg::COORD_W-1:0] mag_next;
    logic                        neg1_reg;
    logic [PW-1:0]               prod_reg;

    logic [PW:0]    sum_round;
    logic           neg2_reg;
    logic [RW-1:0]  r_reg;

    logic [VW-1:0]  sr;
    logic [VW-1:0]  v_next;
    logic [VW-1:0]  v_reg;

    logic           vneg;
    logic [DVW-1:0] abs_next;
    logic [DVW-1:0] abs_reg;
    logic [SW-1:0]  clamp_next;

    logic [SW-1:0]  rem_pipe   [NDIV+1];
    logic [DVW-1:0] dvd_pipe   [NDIV+1];
    logic           neg_pipe   [NDIV+1];
    logic [SW-1:0]  clamp_pipe [NDIV+1];

    logic [SW-1:0]  rem_fin;
    logic [SW-1:0]  wrapped;

    assign size_m1 = size - SW'(1);

    // stage 1: magnitude times (size - 1)
    assign mag_next = coord[tcw_pkg::COORD_W-1] ? (~$unsigned(coord) + 1'b1)
                                                : $unsigned(coord);

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            neg1_reg <= coord[tcw_pkg::COORD_W-1];
            prod_reg <= mag_next * size_m1;
        end
    end

    // stage 2: round half away from zero on the magnitude
    assign sum_round = {1'b0, prod_reg} + (PW+1)'(tcw_pkg::ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            neg2_reg <= neg1_reg;
            r_reg    <= sum_round[PW:tcw_pkg::FRAC_W];
        end
    end

    // stage 3: apply sign, then the optional row flip
    always_comb begin
        sr     = neg2_reg ? (VW'(0) - VW'(r_reg)) : VW'(r_reg);
        v_next = cfg.flip ? (VW'(size_m1) - sr) : sr;
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            v_reg <= v_next;
        end
    end

    // stage 4: magnitude for the divider, clamp-to-edge result on the side
    assign vneg     = v_reg[VW-1];
    assign abs_next = DVW'(vneg ? (VW'(0) - v_reg) : v_reg);

    always_comb begin
        priority if (vneg) begin
            clamp_next = '0;
        end else if (v_reg > VW'(size_m1)) begin
            clamp_next = size_m1;
        end else begin
            clamp_next = v_reg[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            abs_reg       <= abs_next;
            neg_pipe[0]   <= vneg;
            clamp_pipe[0] <= clamp_next;
        end
        for (int j = 0; j < NDIV; j++) begin
            if (load[NPRE+j]) begin
                neg_pipe[j+1]   <= neg_pipe[j];
                clamp_pipe[j+1] <= clamp_pipe[j];
            end
        end
    end

    assign rem_pipe[0] = '0;
    assign dvd_pipe[0] = abs_reg;

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        tcw_rem_step #(
            .SW  (SW),
            .DVW (DVW)
        ) u_step (
            .aclk    (aclk),
            .load    (load[NPRE+j]),
            .size    (size),
            .rem_in  (rem_pipe[j]),
            .dvd_in  (dvd_pipe[j]),
            .rem_out (rem_pipe[j+1]),
            .dvd_out (dvd_pipe[j+1])
        );
    end

    assign rem_fin = rem_pipe[NDIV];

    always_comb begin
        unique case (cfg.mode)
            tcw_pkg::WRAP_REPEAT: begin
                // negative values fold up from the top edge
                wrapped = (neg_pipe[NDIV] && rem_fin != '0) ? (size - rem_fin) : rem_fin;
            end
            tcw_pkg::WRAP_MIRROR: wrapped = rem_fin;
            tcw_pkg::WRAP_CLAMP:  wrapped = clamp_pipe[NDIV];
            default:              wrapped = '0;
        endcase
    end

    assign texel = tcw_pkg::TEXEL_W'(wrapped);

endmodule

@@ design/texel_coordinate_wrap.sv @@
// texel coordinate wrap
// s_ channel: one beat carries a coordinate pair (s_coord_u, s_coord_v) in
// signed q16.16; m_ channel: one beat carries the texel column and row.
// cfg channel: cfg_index selects the register (0 width, 1 height, 2 wrap s,
// 3 wrap t, 4 origin upper-left), cfg_data the value; cfg_ready is always high.
// write registers only while no beat is in flight.
// each axis runs in its own lane: multiply by (size - 1), round, flip the row,
// then a restoring remainder unit resolving 4 bits per stage; an invalid wrap
// mode on either axis forces both outputs to zero at the merge.
// an s_ beat passes 4 front stages plus ceil((size bits + 18) / 4) divider stages
// and then the output register before m_valid rises.
// throughput is one beat per cycle unless m_ready stalls the output; the divider is fully pipelined.
// when m_ready is low the output register holds its beat and the stages
// behind it keep filling until every stage is occupied; only then drops s_ready.
// reset clears all stage valids and sets width 1, height 1, repeat on both
// axes and upper-left origin; no clearing pass is needed.
`include "texel_coordinate_wrap_macros.svh"

module texel_coordinate_wrap #(
    parameter int MAX_DIM = tcw_pkg::MAX_DIM_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tcw_pkg::COORD_W-1:0]  s_coord_u,
    input  logic signed [tcw_pkg::COORD_W-1:0]  s_coord_v,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tcw_pkg::TEXEL_W-1:0]         m_texel_x,
    output logic [tcw_pkg::TEXEL_W-1:0]         m_texel_y,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcw_pkg::CFG_W-1:0]           cfg_data
);

    localparam int SW  = tcw_pkg::size_width(MAX_DIM);
    localparam int NST = tcw_pkg::num_stages(MAX_DIM);
    localparam int EW  = (SW > tcw_pkg::CFG_W) ? SW : tcw_pkg::CFG_W;

    logic [tcw_pkg::CFG_W-1:0] image_width_reg;
    logic [tcw_pkg::CFG_W-1:0] image_height_reg;
    tcw_pkg::wrap_kind_t       wrap_mode_s_reg;
    tcw_pkg::wrap_kind_t       wrap_mode_t_reg;
    logic                      origin_upper_left_reg;

    logic [EW-1:0] w_ext;
    logic [EW-1:0] h_ext;
    logic [SW-1:0] size_w;
    logic [SW-1:0] size_h;

    tcw_pkg::lane_cfg_t cfg_u;
    tcw_pkg::lane_cfg_t cfg_v;
    logic               mode_bad;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_in;
    logic [NST:0]   load;

    logic [tcw_pkg::TEXEL_W-1:0] lane_x;
    logic [tcw_pkg::TEXEL_W-1:0] lane_y;

    logic                        m_valid_reg;
    logic [tcw_pkg::TEXEL_W-1:0] texel_x_reg;
    logic [tcw_pkg::TEXEL_W-1:0] texel_y_reg;
    logic [tcw_pkg::TEXEL_W-1:0] texel_x_next;
    logic [tcw_pkg::TEXEL_W-1:0] texel_y_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg       <= tcw_pkg::CFG_W'(1);
            image_height_reg      <= tcw_pkg::CFG_W'(1);
            wrap_mode_s_reg       <= tcw_pkg::WRAP_REPEAT;
            wrap_mode_t_reg       <= tcw_pkg::WRAP_REPEAT;
            origin_upper_left_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tcw_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                tcw_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                tcw_pkg::CFG_WRAP_S: wrap_mode_s_reg <= tcw_pkg::wrap_kind_t'(cfg_data[1:0]);
                tcw_pkg::CFG_WRAP_T: wrap_mode_t_reg <= tcw_pkg::wrap_kind_t'(cfg_data[1:0]);
                tcw_pkg::CFG_ORIGIN: origin_upper_left_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, oversize saturates at MAX_DIM
    assign w_ext = EW'(image_width_reg);
    assign h_ext = EW'(image_height_reg);

    always_comb begin
        priority if (w_ext == '0) begin
            size_w = SW'(1);
        end else if (w_ext > EW'(MAX_DIM)) begin
            size_w = SW'(MAX_DIM);
        end else begin
            size_w = SW'(w_ext);
        end
        priority if (h_ext == '0) begin
            size_h = SW'(1);
        end else if (h_ext > EW'(MAX_DIM)) begin
            size_h = SW'(MAX_DIM);
        end else begin
            size_h = SW'(h_ext);
        end
    end

    assign cfg_u = '{mode: wrap_mode_s_reg, flip: 1'b0};
    assign cfg_v = '{mode: wrap_mode_t_reg, flip: ~origin_upper_left_reg};
    assign mode_bad = (wrap_mode_s_reg == tcw_pkg::WRAP_INVALID) ||
                      (wrap_mode_t_reg == tcw_pkg::WRAP_INVALID);

    // stage control: a stage loads when any stage at or after it is free
    always_comb begin
        load[NST] = !m_valid_reg || m_ready;
        for (int k = 0; k < NST; k++) begin
            load[k] = load[NST] || (((~vld_reg) >> k) != '0);
        end
    end

    assign s_ready = load[0];
    assign vld_in  = {vld_reg[NST-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (load[k]) begin
                    vld_reg[k] <= vld_in[k];
                end
            end
            if (load[NST]) begin
                m_valid_reg <= vld_reg[NST-1];
            end
        end
    end

    tcw_lane #(
        .MAX_DIM (MAX_DIM)
    ) u_lane_u (
        .aclk  (aclk),
        .load  (load[NST-1:0]),
        .size  (size_w),
        .cfg   (cfg_u),
        .coord (s_coord_u),
        .texel (lane_x)
    );

    tcw_lane #(
        .MAX_DIM (MAX_DIM)
    ) u_lane_v (
        .aclk  (aclk),
        .load  (load[NST-1:0]),
        .size  (size_h),
        .cfg   (cfg_v),
        .coord (s_coord_v),
        .texel (lane_y)
    );

    // merge: a bad mode on either axis zeroes the whole beat
    assign texel_x_next = mode_bad ? '0 : lane_x;
    assign texel_y_next = mode_bad ? '0 : lane_y;

    always_ff @(posedge aclk) begin
        if (load[NST]) begin
            texel_x_reg <= texel_x_next;
            texel_y_reg <= texel_y_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_texel_x = texel_x_reg;
    assign m_texel_y = texel_y_reg;

    `TCW_ASSERT_NEXT(a_accept_fills_first, s_valid && s_ready, vld_reg[0])
    `TCW_ASSERT_NOW(a_backpressure_full, !s_ready, (&vld_reg) && m_valid_reg && !m_ready)
    `TCW_ASSERT_NOW(a_out_from_last, $rose(m_valid_reg), $past(vld_reg[NST-1]))

endmodule
